/* rtl/rwhs_pkg.sv */
// ----------------------------------------------------------------------------
// rwhs_pkg
// Shared types and constants for the signal-strength window switch.
// ----------------------------------------------------------------------------
`default_nettype none

package rwhs_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int LEVEL_W     = 8;
  localparam int PCT_W       = 7;
  localparam int TOTAL_OUT_W = 11;
  localparam int FILL_OUT_W  = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_FLOOR   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CEILING = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_PCT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ON_PCT  = 2'd3;

  // Register values after reset.
  localparam logic [LEVEL_W-1:0] FLOOR_RESET   = 8'd162;
  localparam logic [LEVEL_W-1:0] CEILING_RESET = 8'd218;
  localparam logic [PCT_W-1:0]   OFF_PCT_RESET = 7'd27;
  localparam logic [PCT_W-1:0]   ON_PCT_RESET  = 7'd40;

  // Scale of a full range in percent.
  localparam logic signed [7:0] PCT_SCALE = 8'sd100;

  // Commands from the controller to the datapath, at most one per cycle.
  typedef struct packed {
    logic take;    // capture the sample and read the oldest slot
    logic update;  // update total and ring, first products
    logic mult;    // cross-multiplied comparison terms
    logic decide;  // threshold decision and result load
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/rwhs_ctrl.sv */
// ----------------------------------------------------------------------------
// rwhs_ctrl
// Sequencer for one sample: take, update, multiply, decide, and result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module rwhs_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         sample_valid,
  output logic              sample_stall,
  output logic              result_valid,
  input  wire logic         result_stall,
  output rwhs_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_MULT   = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       result_valid_next;
  logic       out_free;

  // The result register can take a new item when empty or being drained.
  assign out_free     = !result_valid || !result_stall;
  assign sample_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.take   = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_MULT;
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (out_free) begin
          cmd.decide = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign result_valid_next = (result_valid && result_stall) || cmd.decide;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  a_take_then_update: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> cmd.update)
    else $error("update did not follow take");

  a_decide_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> !(result_valid && result_stall))
    else $error("decision overwrote a waiting result");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.update, cmd.mult, cmd.decide}))
    else $error("more than one command in a cycle");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (cmd.update || cmd.mult) |-> sample_stall)
    else $error("input open while an item is in progress");

endmodule

`default_nettype wire

/* rtl/rwhs_dp.sv */
// ----------------------------------------------------------------------------
// rwhs_dp
// Sample ring, running total, fill count, threshold arithmetic and results.
// ----------------------------------------------------------------------------
`default_nettype none

module rwhs_dp #(
  parameter int WINDOW_DEPTH = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire rwhs_pkg::cmd_t                      cmd,
  input  wire logic [rwhs_pkg::SAMPLE_W-1:0]       sample,
  input  wire logic [rwhs_pkg::LEVEL_W-1:0]        range_floor,
  input  wire logic [rwhs_pkg::LEVEL_W-1:0]        range_ceiling,
  input  wire logic [rwhs_pkg::PCT_W-1:0]          off_percent,
  input  wire logic [rwhs_pkg::PCT_W-1:0]          on_percent,
  output logic                                     switch_on,
  output logic                                     switched,
  output logic [rwhs_pkg::TOTAL_OUT_W-1:0]         window_total,
  output logic [rwhs_pkg::FILL_OUT_W-1:0]          window_fill
);

  localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW  = $clog2(WINDOW_DEPTH + 1);
  localparam int TW  = $clog2(255 * WINDOW_DEPTH + 1);
  localparam int PW  = rwhs_pkg::LEVEL_W + FW;       // level times fill
  localparam int DW  = PW + 1;                       // signed difference
  localparam int LW  = DW + rwhs_pkg::PCT_W;         // scaled comparison terms

  logic [rwhs_pkg::SAMPLE_W-1:0] ring [WINDOW_DEPTH];
  logic [rwhs_pkg::SAMPLE_W-1:0] sample_q;
  logic [rwhs_pkg::SAMPLE_W-1:0] oldest_q;
  logic                          drop_q;
  logic [AW-1:0]                 slot;
  logic [FW-1:0]                 fill;
  logic [TW-1:0]                 total;
  logic                          switch_state;
  logic [PW-1:0]                 floor_n;
  logic [PW-1:0]                 span_n;
  logic signed [LW-1:0]          lhs;
  logic signed [LW-1:0]          rhs;

  logic                          full;
  logic [rwhs_pkg::LEVEL_W-1:0]  span;
  logic signed [DW-1:0]          excess;
  logic [rwhs_pkg::PCT_W-1:0]    thresh;
  logic                          turn_off;
  logic                          turn_on;

  assign full   = (fill == FW'(WINDOW_DEPTH));
  assign span   = range_ceiling - range_floor;
  assign excess = $signed(DW'(total)) - $signed(DW'(floor_n));
  // While on, only the turn-off threshold matters, and the other way round.
  assign thresh = switch_state ? off_percent : on_percent;

  assign turn_off = (range_ceiling > range_floor) && switch_state && (lhs < rhs);
  assign turn_on  = (range_ceiling > range_floor) && !switch_state && (lhs > rhs);

  // Ring memory: the slot about to be overwritten is read on take.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      oldest_q <= ring[slot];
    end
    if (cmd.update) begin
      ring[slot] <= sample_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sample_q <= sample;
      drop_q   <= full;
    end
    if (cmd.update) begin
      floor_n <= PW'(range_floor) * PW'(fill);
      span_n  <= PW'(span) * PW'(fill);
    end
    if (cmd.mult) begin
      lhs <= LW'(excess) * LW'(rwhs_pkg::PCT_SCALE);
      rhs <= $signed(LW'(thresh) * LW'(span_n));
    end
  end

  // Window state and switch state.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot         <= '0;
      fill         <= '0;
      total        <= '0;
      switch_state <= 1'b0;
    end else begin
      if (cmd.take && !full) begin
        fill <= fill + FW'(1);
      end
      if (cmd.update) begin
        total <= total - (drop_q ? TW'(oldest_q) : TW'(0)) + TW'(sample_q);
        if (slot == AW'(WINDOW_DEPTH - 1)) begin
          slot <= '0;
        end else begin
          slot <= slot + AW'(1);
        end
      end
      if (cmd.decide && (turn_off || turn_on)) begin
        switch_state <= turn_on;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      switch_on    <= turn_on || (switch_state && !turn_off);
      switched     <= turn_off || turn_on;
      window_total <= rwhs_pkg::TOTAL_OUT_W'(total);
      window_fill  <= rwhs_pkg::FILL_OUT_W'(fill);
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  a_switched_tracks_state: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |=> (switched == (switch_state != $past(switch_state))))
    else $error("switched flag disagrees with switch state");

endmodule

`default_nettype wire

/* rtl/rssi_window_hysteresis_switch.sv */
// ----------------------------------------------------------------------------
// rssi_window_hysteresis_switch
// Moving average of signal-strength samples with a hysteresis switch.
// ----------------------------------------------------------------------------
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------------
//   sample   | sample_valid, sample_stall | sample
//   result   | result_valid, result_stall | switch_on, switched, window_total,
//            |                            | window_fill
//   config   | cfg_we                     | cfg_index, cfg_data
//
// Each sample goes through take and ring read, total update with the
// first products, the cross-multiplied terms, then the threshold decision.
// The sequencer handles one sample at a time and takes no new sample until
// the last one is decided; a stalled result holds the decision step.
// Reset clears the window, the switch and the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module rssi_window_hysteresis_switch #(
  parameter int WINDOW_DEPTH = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                sample_valid,
  output logic                                     sample_stall,
  input  wire logic [rwhs_pkg::SAMPLE_W-1:0]       sample,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic                                     switch_on,
  output logic                                     switched,
  output logic [rwhs_pkg::TOTAL_OUT_W-1:0]         window_total,
  output logic [rwhs_pkg::FILL_OUT_W-1:0]          window_fill,
  input  wire logic                                cfg_we,
  input  wire logic [rwhs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [rwhs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [rwhs_pkg::LEVEL_W-1:0] range_floor;
  logic [rwhs_pkg::LEVEL_W-1:0] range_ceiling;
  logic [rwhs_pkg::PCT_W-1:0]   off_percent;
  logic [rwhs_pkg::PCT_W-1:0]   on_percent;
  rwhs_pkg::cmd_t               cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_floor   <= rwhs_pkg::FLOOR_RESET;
      range_ceiling <= rwhs_pkg::CEILING_RESET;
      off_percent   <= rwhs_pkg::OFF_PCT_RESET;
      on_percent    <= rwhs_pkg::ON_PCT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rwhs_pkg::REG_FLOOR:   range_floor   <= cfg_data;
        rwhs_pkg::REG_CEILING: range_ceiling <= cfg_data;
        rwhs_pkg::REG_OFF_PCT: off_percent   <= cfg_data[rwhs_pkg::PCT_W-1:0];
        rwhs_pkg::REG_ON_PCT:  on_percent    <= cfg_data[rwhs_pkg::PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rwhs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  rwhs_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sample        (sample),
    .range_floor   (range_floor),
    .range_ceiling (range_ceiling),
    .off_percent   (off_percent),
    .on_percent    (on_percent),
    .switch_on     (switch_on),
    .switched      (switched),
    .window_total  (window_total),
    .window_fill   (window_fill)
  );

endmodule

`default_nettype wire

/* tb/rwhs_switch_checker.sv */
// ----------------------------------------------------------------------------
// rwhs_switch_checker
// Watches the sample, result and register channels of the signal-strength
// window switch. It keeps its own copy of the window and the registers and
// checks every result that is taken against the oldest one still owed.
// ----------------------------------------------------------------------------
module rwhs_switch_checker #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  input  logic                               sample_stall,
  input  logic [rwhs_pkg::SAMPLE_W-1:0]      sample,
  input  logic                               result_valid,
  input  logic                               result_stall,
  input  logic                               switch_on,
  input  logic                               switched,
  input  logic [rwhs_pkg::TOTAL_OUT_W-1:0]   window_total,
  input  logic [rwhs_pkg::FILL_OUT_W-1:0]    window_fill,
  input  logic                               cfg_we,
  input  logic [rwhs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rwhs_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                 mismatch_count,
  output int                                 pending,
  output int                                 results_checked,
  output int                                 switch_events
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                             on_state;
    logic                             toggled;
    logic [rwhs_pkg::TOTAL_OUT_W-1:0] total;
    logic [rwhs_pkg::FILL_OUT_W-1:0]  fill;
  } window_report_t;

  window_report_t window_reports_q[$];

  // Register copies.
  logic [rwhs_pkg::LEVEL_W-1:0] level_floor;
  logic [rwhs_pkg::LEVEL_W-1:0] level_ceiling;
  logic [rwhs_pkg::PCT_W-1:0]   pct_off;
  logic [rwhs_pkg::PCT_W-1:0]   pct_on;

  // Window copy. Totals are kept wide; only the outputs are truncated.
  logic [rwhs_pkg::SAMPLE_W-1:0] ring [WINDOW_DEPTH];
  int unsigned                   slot_idx;
  int unsigned                   fill_n;
  int unsigned                   sum_n;
  bit                            sw_on;

  initial begin
    mismatch_count  = 0;
    results_checked = 0;
    switch_events   = 0;
    pending         = 0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH at %0t, result %0d, %s: got %0d, expected %0d",
             $realtime, results_checked, what, got, want);
    mismatch_count++;
  endtask

  // True when the average, as a percentage of the range, lies strictly above
  // (or below) the threshold. Cross-multiplied so no division is needed.
  function automatic bit pct_crosses(input logic [rwhs_pkg::PCT_W-1:0] thr,
                                     input bit above);
    longint lhs;
    longint rhs;
    lhs = (longint'(sum_n) - longint'(level_floor) * longint'(fill_n)) * 100;
    rhs = longint'(thr) * (longint'(level_ceiling) - longint'(level_floor))
          * longint'(fill_n);
    return above ? (lhs > rhs) : (lhs < rhs);
  endfunction

  task automatic advance_window(input logic [rwhs_pkg::SAMPLE_W-1:0] s);
    window_report_t r;
    bit             changed;
    changed = 1'b0;
    // A full window gives up its oldest sample before the new one goes in.
    if (fill_n >= WINDOW_DEPTH) begin
      sum_n  -= 32'(ring[slot_idx]);
      fill_n  = WINDOW_DEPTH;
    end else begin
      fill_n++;
    end
    ring[slot_idx] = s;
    sum_n         += 32'(s);
    slot_idx       = (slot_idx + 1) % WINDOW_DEPTH;
    // An empty range leaves the switch where it is. Turn-off is tested first.
    if (level_ceiling > level_floor) begin
      if (sw_on && pct_crosses(pct_off, 1'b0)) begin
        sw_on   = 1'b0;
        changed = 1'b1;
      end else if (!sw_on && pct_crosses(pct_on, 1'b1)) begin
        sw_on   = 1'b1;
        changed = 1'b1;
      end
    end
    r.on_state = sw_on;
    r.toggled  = changed;
    r.total    = rwhs_pkg::TOTAL_OUT_W'(sum_n);
    r.fill     = rwhs_pkg::FILL_OUT_W'(fill_n);
    window_reports_q = {window_reports_q, r};
  endtask

  task automatic check_result();
    window_report_t r;
    if (window_reports_q.size() == 0) begin
      report_mismatch("result with nothing owed", 16'(window_total), 16'd0);
    end else begin
      r = window_reports_q.pop_front();
      if (switch_on !== r.on_state)
        report_mismatch("switch_on", 16'(switch_on), 16'(r.on_state));
      if (switched !== r.toggled)
        report_mismatch("switched", 16'(switched), 16'(r.toggled));
      if (window_total !== r.total)
        report_mismatch("window_total", 16'(window_total), 16'(r.total));
      if (window_fill !== r.fill)
        report_mismatch("window_fill", 16'(window_fill), 16'(r.fill));
      if (r.toggled) switch_events++;
    end
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      level_floor   = rwhs_pkg::FLOOR_RESET;
      level_ceiling = rwhs_pkg::CEILING_RESET;
      pct_off       = rwhs_pkg::OFF_PCT_RESET;
      pct_on        = rwhs_pkg::ON_PCT_RESET;
      slot_idx      = 0;
      fill_n        = 0;
      sum_n         = 0;
      sw_on         = 1'b0;
      window_reports_q.delete();
    end else begin
      if (result_valid && !result_stall) check_result();
      if (sample_valid && !sample_stall) advance_window(sample);
      if (cfg_we) begin
        case (cfg_index)
          rwhs_pkg::REG_FLOOR:   level_floor   = cfg_data[rwhs_pkg::LEVEL_W-1:0];
          rwhs_pkg::REG_CEILING: level_ceiling = cfg_data[rwhs_pkg::LEVEL_W-1:0];
          rwhs_pkg::REG_OFF_PCT: pct_off       = cfg_data[rwhs_pkg::PCT_W-1:0];
          rwhs_pkg::REG_ON_PCT:  pct_on        = cfg_data[rwhs_pkg::PCT_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= window_reports_q.size();
  end

endmodule

/* tb/rssi_window_hysteresis_switch_tb.sv */
// ----------------------------------------------------------------------------
// rssi_window_hysteresis_switch_tb
// Drives signal-strength samples and register settings into the window
// switch under several idling mixes and one long result hold-off. A checker
// beside the block predicts and compares every result; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module rssi_window_hysteresis_switch_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_DEPTH = 8;
  localparam int HOLD_CYCLES  = 400;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             sample_valid = 1'b0;
  logic                             sample_stall;
  logic [rwhs_pkg::SAMPLE_W-1:0]    sample = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic                             switch_on;
  logic                             switched;
  logic [rwhs_pkg::TOTAL_OUT_W-1:0] window_total;
  logic [rwhs_pkg::FILL_OUT_W-1:0]  window_fill;
  logic                             cfg_we = 1'b0;
  logic [rwhs_pkg::CFG_INDEX_W-1:0] cfg_index = rwhs_pkg::REG_FLOOR;
  logic [rwhs_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatch_count;
  int pending;
  int results_checked;
  int switch_events;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int settings_loaded = 0;

  rssi_window_hysteresis_switch #(.WINDOW_DEPTH(WINDOW_DEPTH)) dut (
    .clk, .rst,
    .sample_valid, .sample_stall, .sample,
    .result_valid, .result_stall,
    .switch_on, .switched, .window_total, .window_fill,
    .cfg_we, .cfg_index, .cfg_data
  );

  rwhs_switch_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_checker (
    .clk, .rst,
    .sample_valid, .sample_stall, .sample,
    .result_valid, .result_stall,
    .switch_on, .switched, .window_total, .window_fill,
    .cfg_we, .cfg_index, .cfg_data,
    .mismatch_count, .pending, .results_checked, .switch_events
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side. A hold-off request keeps the result stalled for a long,
  // counted stretch so that the block fills up and stalls its input.
  initial begin
    int k;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  task automatic push_sample(input logic [rwhs_pkg::SAMPLE_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= v;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rwhs_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rwhs_pkg::CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [7:0] f, input logic [7:0] c,
                             input logic [7:0] offp, input logic [7:0] onp);
    write_reg(rwhs_pkg::REG_FLOOR, f);
    write_reg(rwhs_pkg::REG_CEILING, c);
    write_reg(rwhs_pkg::REG_OFF_PCT, offp);
    write_reg(rwhs_pkg::REG_ON_PCT, onp);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_loaded++;
  endtask

  // One phase: settle, load a setting, then send samples in runs around the
  // configured range so that the average actually crosses the thresholds.
  task automatic run_phase(input idle_mode_t mode, input logic [7:0] f,
                           input logic [7:0] c, input logic [7:0] offp,
                           input logic [7:0] onp, input int n, input bit with_hold);
    int lo;
    int hi;
    int level;
    int run_len;
    int v;
    int k;
    int sent;
    wait_idle();
    load_config(f, c, offp, onp);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 88; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 88; end
      default:       begin send_idle_pct = 34; recv_stall_pct = 34; end
    endcase
    if (with_hold) hold_req <= 1'b1;
    lo = (f < c) ? int'(f) : int'(c);
    hi = (f < c) ? int'(c) : int'(f);
    lo = (lo > 30) ? lo - 30 : 0;
    hi = (hi < 225) ? hi + 30 : 255;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 4) == 0) begin
        push_sample(rwhs_pkg::SAMPLE_W'($urandom_range(0, 255)));
        sent++;
      end else begin
        level   = $urandom_range(lo, hi);
        run_len = $urandom_range(3, 14);
        for (k = 0; k < run_len && sent < n; k++) begin
          v = level + int'($urandom_range(0, 8)) - 4;
          push_sample((v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : 8'(v)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int         p;
    int         r;
    logic [7:0] f;
    logic [7:0] c;
    logic [7:0] offp;
    logic [7:0] onp;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed items on the reset setting: the sample extremes, a climb that
    // turns the switch on, a fall that turns it off, a fully loaded window
    // at the largest total, and wrap-around of the ring.
    push_sample(8'd0);
    push_sample(8'd255);
    repeat (4) push_sample(8'd218);
    repeat (6) push_sample(8'd162);
    repeat (8) push_sample(8'd255);
    repeat (3) push_sample(8'd0);

    // Long hold-off on the result side while the sender keeps offering.
    run_phase(IDLE_NONE, 8'd162, 8'd218, 8'd27, 8'd40, 30, 1'b1);

    // Extreme settings: full range with unreachable thresholds, inverted and
    // equal ranges, thresholds written with the top bit set, opposite
    // thresholds so both tests hold at once, and a one-step range.
    run_phase(IDLE_NONE,     8'd0,   8'd255, 8'd0,   8'd100, 60, 1'b0);
    run_phase(IDLE_SENDER,   8'd255, 8'd0,   8'd50,  8'd10,  60, 1'b0);
    run_phase(IDLE_RECEIVER, 8'd100, 8'd100, 8'd20,  8'd30,  60, 1'b0);
    run_phase(IDLE_BOTH,     8'd0,   8'd255, 8'hFF,  8'h80,  60, 1'b0);
    run_phase(IDLE_NONE,     8'd0,   8'd255, 8'd100, 8'd0,   60, 1'b0);
    run_phase(IDLE_SENDER,   8'd254, 8'd255, 8'd50,  8'd50,  60, 1'b0);

    for (p = 0; p < 10; p++) begin
      r = $urandom_range(0, 7);
      f = 8'($urandom_range(0, 220));
      c = (r == 0) ? 8'($urandom_range(0, f)) : 8'($urandom_range(f + 1, 255));
      offp = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 100))};
      onp  = {1'($urandom_range(0, 1)), 7'($urandom_range(offp[6:0], 100))};
      if (r == 1) onp[6:0] = 7'($urandom_range(0, 127));
      run_phase(idle_mode_t'(p % 4), f, c, offp, onp, 120, 1'b0);
    end

    wait_idle();
    $display("Covered %0d samples over %0d register settings, four idling mixes",
             items_sent, settings_loaded + 1);
    $display("and a long result hold-off; %0d results checked, %0d switch changes.",
             results_checked, switch_events);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rwhs_pkg.sv
rtl/rwhs_ctrl.sv
rtl/rwhs_dp.sv
rtl/rssi_window_hysteresis_switch.sv
tb/rwhs_switch_checker.sv
tb/rssi_window_hysteresis_switch_tb.sv
